### rtl/core/llf_pkg.sv
// ----------------------------------------------------------------------------
// llf_pkg
// Shared types and constants of the LOAS/LATM framer: controller states,
// header field codes, packer commands, status codes and register map.
// ----------------------------------------------------------------------------
package llf_pkg;

    localparam int MAX_FRAME_BYTES = 8191;
    localparam int ASC_MAX_BITS    = 64;

    localparam int SIZE_W  = 13;
    localparam int LEN_W   = 14;
    localparam int RUNS_W  = 6;
    localparam int ALEN_W  = 7;
    localparam int FC_W    = 16;

    localparam logic [7:0]        LOAS_SYNC0     = 8'h56;
    localparam logic [2:0]        LOAS_SYNC1_HI  = 3'h7;
    localparam logic [LEN_W-1:0]  LOAS_LEN_MAX   = 14'h1fff;
    localparam logic [7:0]        ADTS_SYNC_BYTE = 8'hff;
    localparam logic [3:0]        ADTS_SYNC_NIB  = 4'hf;
    localparam logic [7:0]        DSE_ID_MASK    = 8'he1;
    localparam logic [7:0]        DSE_ID_VALUE   = 8'h81;
    localparam logic [7:0]        DSE_ALIGN_CLR  = 8'hfe;
    localparam logic [15:0]       MUX_INTERVAL_RST = 16'd20;

    // audioMuxVersion .. numLayer, MSB first
    localparam logic [14:0] SMC_HEAD      = 15'h2000;
    localparam int          SMC_HEAD_BITS = 15;
    // frameLengthType, buffer fullness, otherDataPresent, crcCheckPresent
    localparam logic [12:0] SMC_TAIL      = 13'h03fc;
    localparam int          SMC_TAIL_BITS = 13;
    // header bits in front of the payload length info when the config is sent,
    // plus 7 for rounding up to bytes
    localparam logic [ALEN_W-1:0] SMC_FIXED_ROUND = 7'd36;

    localparam int MOD_STEPS = 17;

    // register indexes (byte address / 8)
    localparam logic [1:0] REG_MUX_INTERVAL = 2'd0;
    localparam logic [1:0] REG_ASC_BITS     = 2'd1;
    localparam logic [1:0] REG_ASC_LENGTH   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ADTS = 2'd1;
    localparam logic [1:0] ST_SIZE = 2'd2;

    // input operation codes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MODW,
        S_LEN,
        S_SYNC0,
        S_SYNC1,
        S_SYNC2,
        S_HDR,
        S_PAD,
        S_PAYLOAD,
        S_TAIL,
        S_STATUS
    } t_state;

    typedef enum logic [2:0] {
        F_USE,
        F_FIX,
        F_ASC,
        F_TAIL,
        F_FF,
        F_REM,
        F_DONE
    } t_field;

    typedef enum logic [2:0] {
        PK_NONE,
        PK_CLEAR,
        PK_BIT,
        PK_DATA,
        PK_FLUSH
    } t_pk_cmd;

    typedef struct packed {
        logic load;
        logic step;
    } t_seq_cmd;

    typedef struct packed {
        logic pend;
        logic full7;
    } t_pk_stat;

endpackage

### rtl/core/llf_mod_unit.sv
// ----------------------------------------------------------------------------
// llf_mod_unit
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module llf_mod_unit
    import llf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_busy,
    output logic [15:0] o_rem
);

    logic        r_busy;
    logic [4:0]  r_step;
    logic [16:0] r_dvd;
    logic [15:0] r_rem;
    logic [15:0] r_div;
    logic [16:0] trial;
    logic [15:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[16]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = 16'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= 5'(MOD_STEPS - 1);
        end else if (r_busy) begin
            r_step <= r_step - 5'd1;
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[15:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

### rtl/core/llf_bit_seq.sv
// ----------------------------------------------------------------------------
// llf_bit_seq
// AudioMuxElement header bit source: walks the header fields and shifts
// them out MSB first, one bit per step.
// ----------------------------------------------------------------------------
module llf_bit_seq
    import llf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_seq_cmd          i_cmd,
    input  logic              i_smc,
    input  logic [ALEN_W-1:0] i_alen,
    input  logic [63:0]       i_asc,
    input  logic [RUNS_W-1:0] i_runs,
    input  logic [7:0]        i_rem,
    output logic              o_bit,
    output logic              o_last
);

    t_field            r_field;
    logic [63:0]       r_sr;
    logic [ALEN_W-1:0] r_cnt;
    logic [RUNS_W-1:0] r_runs;

    t_field            n_field;
    logic [63:0]       n_sr;
    logic [ALEN_W-1:0] n_cnt;
    logic [RUNS_W-1:0] n_runs;

    // pick the field that follows the current one, skipping empty ones
    always_comb begin
        n_runs = r_runs;
        case (r_field)
            F_USE: begin
                if (i_smc) begin
                    n_field = F_FIX;
                end else if (r_runs != '0) begin
                    n_field = F_FF;
                end else begin
                    n_field = F_REM;
                end
            end
            F_FIX:  n_field = (i_alen != '0) ? F_ASC : F_TAIL;
            F_ASC:  n_field = F_TAIL;
            F_TAIL: n_field = (r_runs != '0) ? F_FF : F_REM;
            F_FF: begin
                n_runs  = r_runs - RUNS_W'(1);
                n_field = (n_runs != '0) ? F_FF : F_REM;
            end
            default: n_field = F_DONE;
        endcase

        case (n_field)
            F_FIX: begin
                n_sr  = {SMC_HEAD, 49'b0};
                n_cnt = ALEN_W'(SMC_HEAD_BITS);
            end
            F_ASC: begin
                n_sr  = i_asc;
                n_cnt = i_alen;
            end
            F_TAIL: begin
                n_sr  = {SMC_TAIL, 51'b0};
                n_cnt = ALEN_W'(SMC_TAIL_BITS);
            end
            F_FF: begin
                n_sr  = {8'hff, 56'b0};
                n_cnt = ALEN_W'(8);
            end
            F_REM: begin
                n_sr  = {i_rem, 56'b0};
                n_cnt = ALEN_W'(8);
            end
            default: begin
                n_sr  = '0;
                n_cnt = ALEN_W'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field <= F_DONE;
        end else if (i_cmd.load) begin
            r_field <= F_USE;
        end else if (i_cmd.step && r_cnt == ALEN_W'(1)) begin
            r_field <= n_field;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sr   <= {~i_smc, 63'b0};
            r_cnt  <= ALEN_W'(1);
            r_runs <= i_runs;
        end else if (i_cmd.step) begin
            if (r_cnt == ALEN_W'(1)) begin
                r_sr   <= n_sr;
                r_cnt  <= n_cnt;
                r_runs <= n_runs;
            end else begin
                r_sr  <= {r_sr[62:0], 1'b0};
                r_cnt <= r_cnt - ALEN_W'(1);
            end
        end
    end

    assign o_bit  = r_sr[63];
    assign o_last = (r_field == F_REM) && (r_cnt == ALEN_W'(1));

endmodule

### rtl/core/llf_byte_pack.sv
// ----------------------------------------------------------------------------
// llf_byte_pack
// Bit accumulator: packs header bits into bytes and realigns payload bytes
// behind the pending header bits.
// ----------------------------------------------------------------------------
module llf_byte_pack
    import llf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_pk_cmd    i_cmd,
    input  logic       i_bit,
    input  logic [7:0] i_data,
    output logic [7:0] o_byte,
    output logic       o_emit,
    output t_pk_stat   o_stat
);

    logic [6:0]  r_acc;
    logic [2:0]  r_cnt;
    logic [6:0]  n_acc;
    logic [2:0]  n_cnt;
    logic [14:0] merged;
    logic [7:0]  keep_mask;

    always_comb begin
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        o_byte    = 8'h00;
        o_emit    = 1'b0;
        merged    = '0;
        keep_mask = ~(8'hff << r_cnt);
        case (i_cmd)
            PK_CLEAR: begin
                n_acc = '0;
                n_cnt = '0;
            end
            PK_BIT: begin
                if (r_cnt == 3'd7) begin
                    o_byte = {r_acc, i_bit};
                    o_emit = 1'b1;
                    n_acc  = '0;
                    n_cnt  = '0;
                end else begin
                    n_acc = {r_acc[5:0], i_bit};
                    n_cnt = r_cnt + 3'd1;
                end
            end
            PK_DATA: begin
                merged = {r_acc, i_data} >> r_cnt;
                o_byte = merged[7:0];
                o_emit = 1'b1;
                n_acc  = 7'(i_data & keep_mask);
            end
            PK_FLUSH: begin
                // zero padding up to the byte boundary
                merged = {r_acc, 8'h00} >> r_cnt;
                o_byte = merged[7:0];
                o_emit = (r_cnt != '0);
                n_acc  = '0;
                n_cnt  = '0;
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

    assign o_stat.pend  = (r_cnt != '0);
    assign o_stat.full7 = (r_cnt == 3'd7);

endmodule

### rtl/core/loas_latm_framer_core.sv
// ----------------------------------------------------------------------------
// loas_latm_framer_core
// Wraps raw AAC frames into LOAS/LATM with an APB register port.
// ----------------------------------------------------------------------------
// A frame is one start transfer (tuser 0) carrying the payload length and the
// first two payload bytes, followed by that many payload transfers (tuser 1).
// A start transfer first runs the checks and the mux-interval counter
// update (a bit-serial remainder unit), then sends the sync header, and then
// the AudioMuxElement header one bit per cycle while the output is not stalled:
// 9 to 265 bits for the stream mux flag and the length info plus 28 to 92
// for the mux config when it is sent. Payload transfers then pass at one
// per cycle while the output is not stalled, shifted behind the pending
// header bits; the last one may add one padding byte. Rejected frames give a
// single transfer with tlast set and the reason in tuser. Each output
// transfer sits in an output register, so a stall on the master side holds
// the block without losing data. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module loas_latm_framer_core
    import llf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [12:0] frame_length, [20:13] lead_byte_zero, [28:21] lead_byte_one,
    // [36:29] data_byte, [39:37] zero
    input  logic [39:0] i_s_tdata,
    // [0] operation
    input  logic        i_s_tuser,
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] out_byte
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast,
    // [1:0] status
    output logic [1:0]  o_m_tuser,
    // register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    output logic [63:0] o_prdata,
    output logic        o_pready
);

    // configuration
    logic [15:0]       r_mux_interval;
    logic [63:0]       r_asc_bits;
    logic [ALEN_W-1:0] r_asc_length;
    logic              cfg_wr;

    // control and frame state
    t_state            r_state;
    t_state            n_state;
    logic [FC_W-1:0]   r_fc;
    logic [SIZE_W-1:0] r_size;
    logic [7:0]        r_b0;
    logic [7:0]        r_b1;
    logic              r_first;
    logic [SIZE_W-1:0] r_left;
    logic              r_smc;
    logic [RUNS_W-1:0] r_q;
    logic [3:0]        r_hb;
    logic [7:0]        r_rem;
    logic [SIZE_W-1:0] r_len;
    logic [1:0]        r_status;

    // output register
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_end;
    logic [1:0]        r_out_status;

    // datapath helpers
    logic              in_acc;
    logic              in_start;
    logic              in_pay;
    logic              out_free;
    logic              is_adts;
    logic              is_big;
    logic [ALEN_W-1:0] alen;
    logic [15:0]       mod_div;
    logic [LEN_W-1:0]  q_sum;
    logic [LEN_W-1:0]  len_calc;
    logic [LEN_W-1:0]  rem_calc;
    logic [7:0]        pay_byte;

    // sub-unit controls
    t_seq_cmd          seq_cmd;
    logic              seq_bit;
    logic              seq_last;
    t_pk_cmd           pk_cmd;
    logic [7:0]        pk_byte;
    logic              pk_emit;
    t_pk_stat          pk_stat;
    logic              mod_start;
    logic              mod_busy;
    logic [15:0]       mod_rem;

    // output controls
    logic              ld;
    logic [7:0]        ld_byte;
    logic              ld_end;
    logic [1:0]        ld_status;

    // ---------------- register port ----------------
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mux_interval <= MUX_INTERVAL_RST;
            r_asc_bits     <= '0;
            r_asc_length   <= '0;
        end else if (cfg_wr) begin
            case (i_paddr[4:3])
                REG_MUX_INTERVAL: r_mux_interval <= i_pwdata[15:0];
                REG_ASC_BITS:     r_asc_bits     <= i_pwdata;
                REG_ASC_LENGTH:   r_asc_length   <= i_pwdata[ALEN_W-1:0];
                default:          r_asc_length   <= r_asc_length;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[4:3])
            REG_MUX_INTERVAL: o_prdata = {48'b0, r_mux_interval};
            REG_ASC_BITS:     o_prdata = r_asc_bits;
            REG_ASC_LENGTH:   o_prdata = {57'b0, r_asc_length};
            default:          o_prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    assign out_free = !r_out_valid || i_m_tready;
    assign in_acc   = i_s_tvalid && o_s_tready;
    assign in_start = in_acc && (i_s_tuser == OP_START);
    assign in_pay   = in_acc && (i_s_tuser == OP_PAYLOAD);

    assign is_adts = (r_size > SIZE_W'(2)) && (r_b0 == ADTS_SYNC_BYTE)
                     && (r_b1[7:4] == ADTS_SYNC_NIB);
    assign is_big  = (r_size > SIZE_W'(MAX_FRAME_BYTES));
    assign alen    = (r_asc_length > ALEN_W'(ASC_MAX_BITS)) ? ALEN_W'(ASC_MAX_BITS)
                                                            : r_asc_length;
    assign mod_div = (r_mux_interval == '0) ? 16'd1 : r_mux_interval;

    // size / 255 without a divider, exact for the 13-bit range
    assign q_sum    = LEN_W'(r_size) + LEN_W'(r_size[SIZE_W-1:8]) + LEN_W'(1);
    assign len_calc = LEN_W'(r_size) + LEN_W'(r_q) + LEN_W'(1) + LEN_W'(r_hb);
    assign rem_calc = LEN_W'(r_size) + LEN_W'(r_q) - {r_q, 8'b0};

    assign pay_byte = i_s_tdata[36:29] & (r_first ? DSE_ALIGN_CLR : 8'hff);

    always_ff @(posedge i_clk) begin
        if (in_start) begin
            r_size  <= i_s_tdata[12:0];
            r_b0    <= i_s_tdata[20:13];
            r_b1    <= i_s_tdata[28:21];
            r_first <= ((i_s_tdata[20:13] & DSE_ID_MASK) == DSE_ID_VALUE);
            r_left  <= i_s_tdata[12:0];
        end else if (in_pay && r_state == S_PAYLOAD) begin
            r_first <= 1'b0;
            r_left  <= r_left - SIZE_W'(1);
        end
        if (r_state == S_CHECK) begin
            r_q      <= q_sum[LEN_W-1:8];
            r_smc    <= (r_fc == '0);
            r_hb     <= (r_fc == '0) ? 4'((alen + SMC_FIXED_ROUND) >> 3) : 4'd1;
            r_status <= is_adts ? ST_ADTS : ST_SIZE;
        end
        if (r_state == S_LEN) begin
            r_rem <= rem_calc[7:0];
            r_len <= len_calc[SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc <= '0;
        end else if (r_state == S_MODW && !mod_busy) begin
            r_fc <= mod_rem;
        end
    end

    // ---------------- sub-units ----------------
    llf_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (17'(r_fc) + 17'd1),
        .i_divisor  (mod_div),
        .o_busy     (mod_busy),
        .o_rem      (mod_rem)
    );

    llf_bit_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (seq_cmd),
        .i_smc   (r_smc),
        .i_alen  (alen),
        .i_asc   (r_asc_bits),
        .i_runs  (r_q),
        .i_rem   (r_rem),
        .o_bit   (seq_bit),
        .o_last  (seq_last)
    );

    llf_byte_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pk_cmd),
        .i_bit   (seq_bit),
        .i_data  (pay_byte),
        .o_byte  (pk_byte),
        .o_emit  (pk_emit),
        .o_stat  (pk_stat)
    );

    // ---------------- controller: next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: n_state = (is_adts || is_big) ? S_STATUS : S_MODW;
            S_MODW: begin
                if (!mod_busy) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: n_state = (len_calc > LOAS_LEN_MAX) ? S_STATUS : S_SYNC0;
            S_SYNC0: if (out_free) begin
                n_state = S_SYNC1;
            end
            S_SYNC1: if (out_free) begin
                n_state = S_SYNC2;
            end
            S_SYNC2: if (out_free) begin
                n_state = S_HDR;
            end
            S_HDR: begin
                if (out_free && seq_last) begin
                    if (r_size != '0) begin
                        n_state = S_PAYLOAD;
                    end else if (pk_stat.full7) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAYLOAD: begin
                if (in_start) begin
                    n_state = S_CHECK;
                end else if (in_pay && r_left == SIZE_W'(1)) begin
                    n_state = pk_stat.pend ? S_TAIL : S_IDLE;
                end
            end
            S_PAD, S_TAIL, S_STATUS: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- controller: outputs ----------------
    always_comb begin
        o_s_tready = 1'b0;
        seq_cmd    = '0;
        pk_cmd     = PK_NONE;
        mod_start  = 1'b0;
        ld         = 1'b0;
        ld_byte    = 8'h00;
        ld_end     = 1'b0;
        ld_status  = ST_OK;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (in_start) begin
                    pk_cmd = PK_CLEAR;
                end
            end
            S_CHECK: mod_start = !(is_adts || is_big);
            S_LEN: seq_cmd.load = 1'b1;
            S_SYNC0: begin
                ld      = out_free;
                ld_byte = LOAS_SYNC0;
            end
            S_SYNC1: begin
                ld      = out_free;
                ld_byte = {LOAS_SYNC1_HI, r_len[12:8]};
            end
            S_SYNC2: begin
                ld      = out_free;
                ld_byte = r_len[7:0];
            end
            S_HDR: begin
                if (out_free) begin
                    seq_cmd.step = 1'b1;
                    pk_cmd       = PK_BIT;
                    ld           = pk_emit;
                    ld_byte      = pk_byte;
                    ld_end       = seq_last && (r_size == '0);
                end
            end
            S_PAYLOAD: begin
                o_s_tready = out_free;
                if (in_start) begin
                    pk_cmd = PK_CLEAR;
                end else if (in_pay) begin
                    pk_cmd  = PK_DATA;
                    ld      = 1'b1;
                    ld_byte = pk_byte;
                    ld_end  = (r_left == SIZE_W'(1)) && !pk_stat.pend;
                end
            end
            S_PAD, S_TAIL: begin
                if (out_free) begin
                    pk_cmd  = PK_FLUSH;
                    ld      = 1'b1;
                    ld_byte = pk_byte;
                    ld_end  = 1'b1;
                end
            end
            S_STATUS: begin
                ld        = out_free;
                ld_end    = 1'b1;
                ld_status = r_status;
            end
            default: o_s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_out_byte   <= ld_byte;
            r_out_end    <= ld_end;
            r_out_status <= ld_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_end;
    assign o_m_tuser  = r_out_status;

    // ---------------- assertions ----------------
    ap_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_OK) |-> (o_m_tlast && o_m_tdata == 8'h00))
        else $error("rejection transfer without tlast or with nonzero data");

    ap_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAYLOAD) |-> (r_left != '0))
        else $error("payload phase with no bytes left");

    ap_mod_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN) |-> (!mod_busy && $past(r_state) == S_MODW))
        else $error("length check entered before counter update finished");

    ap_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !ld)
        else $error("output register loaded while stalled");

endmodule
